FILE: hw/rtl/bcd_adjust_unit_top_macros.svh
// assertion macros for the decimal adjust unit checker
`ifndef BCD_ADJUST_UNIT_TOP_MACROS_SVH
`define BCD_ADJUST_UNIT_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define BAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define BAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/bau_pkg.sv
// types and constants shared by the decimal adjust unit and its checker
package bau_pkg;

  localparam logic [2:0] CMD_DAA = 3'd0;
  localparam logic [2:0] CMD_DAS = 3'd1;
  localparam logic [2:0] CMD_AAA = 3'd2;
  localparam logic [2:0] CMD_AAS = 3'd3;
  localparam logic [2:0] CMD_AAM = 3'd4;
  localparam logic [2:0] CMD_AAD = 3'd5;

  localparam logic [3:0]  NIB_MAX   = 4'd9;
  localparam logic [7:0]  BCD_MAX   = 8'h99;
  localparam logic [7:0]  ADJ_LO    = 8'h06;
  localparam logic [7:0]  ADJ_HI    = 8'h60;
  localparam logic [15:0] ADJ_AX    = 16'h0106;
  localparam logic [15:0] ADJ_AX_LO = 16'h0006;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] al_in;
    logic [7:0] ah_in;
    logic       carry_in;
    logic       aux_carry_in;
    logic [7:0] base;
  } bau_in_t;

  typedef struct packed {
    logic [7:0] al_out;
    logic [7:0] ah_out;
    logic       carry_out;
    logic       aux_carry_out;
    logic       sign_flag;
    logic       zero_flag;
    logic       parity_flag;
    logic       szp_written;
    logic       divide_error;
  } bau_out_t;

endpackage

FILE: hw/rtl/bcd_adjust_unit_top.sv
// decimal adjust unit: DAA, DAS, AAA, AAS, AAM and AAD in a four-stage pipeline
//
// cmd channel: cmd_valid / cmd_stall with cmd_word (command, AL, AH, CF, AF, base).
// res channel: res_valid / res_stall with res_word (AL, AH, CF, AF, SF, ZF, PF,
//   szp_written, divide_error). one result word per command word, in order.
// a word is taken at a rising edge with valid high and stall low.
// a taken word passes the s1, s2, s3 and res_word registers in order.
// throughput: one word per cycle unless res is stalled; the depth is set by the
//   AAM division, which resolves two quotient bits in each of the four stages,
//   with the AAD multiply and add in stages two and three.
// a stall on res holds the output register and freezes all stages; cmd_stall
//   follows res_stall while a result is waiting, so nothing is dropped.
// reset (rst, synchronous) clears all stage valid bits; payload is not reset.
// an AAM with a base of zero sets divide_error and passes AL, AH, CF, AF.
module bcd_adjust_unit_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  bau_pkg::bau_in_t  cmd_word,
  output logic              res_valid,
  input  logic              res_stall,
  output bau_pkg::bau_out_t res_word
);
  import bau_pkg::*;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] base;
    logic [7:0] dvd;
    logic [7:0] ah_orig;
    logic [7:0] rem;
    logic [7:0] quo;
    logic [7:0] prod;
    logic [7:0] res_al;
    logic [7:0] res_ah;
    logic       res_cf;
    logic       res_af;
  } stage_t;

  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nb,
                                          input logic [7:0] dvs);
    logic [8:0] t;
    t = {rem, nb};
    if (t >= {1'b0, dvs}) begin
      div_step = {1'b1, 8'(t - {1'b0, dvs})};
    end else begin
      div_step = {1'b0, t[7:0]};
    end
  endfunction

  logic     advance;
  logic     v1, v2, v3;
  stage_t   s1, s2, s3;
  stage_t   s1_next, s2_next, s3_next;
  bau_out_t res_word_next;

  assign advance   = !(res_valid && res_stall);
  assign cmd_stall = res_valid && res_stall;

  // stage 1: adjust ops, quotient bits 7..6
  always_comb begin
    logic        lo, hi;
    logic [15:0] ax;
    logic [8:0]  da, db;
    lo = (cmd_word.al_in[3:0] > NIB_MAX) || cmd_word.aux_carry_in;
    hi = (cmd_word.al_in > BCD_MAX) || cmd_word.carry_in;
    ax = '0;
    s1_next         = '0;
    s1_next.cmd     = cmd_word.cmd;
    s1_next.base    = cmd_word.base;
    s1_next.dvd     = cmd_word.al_in;
    s1_next.ah_orig = cmd_word.ah_in;
    s1_next.res_al  = cmd_word.al_in;
    s1_next.res_ah  = cmd_word.ah_in;
    s1_next.res_cf  = cmd_word.carry_in;
    s1_next.res_af  = cmd_word.aux_carry_in;
    unique case (cmd_word.cmd)
      CMD_DAA: begin
        if (lo) begin
          s1_next.res_al = cmd_word.al_in + ADJ_LO;
        end
        if (hi) begin
          s1_next.res_al = s1_next.res_al + ADJ_HI;
        end
        s1_next.res_cf = hi;
        s1_next.res_af = lo;
      end
      CMD_DAS: begin
        s1_next.res_cf = 1'b0;
        if (lo) begin
          s1_next.res_cf = cmd_word.carry_in || (cmd_word.al_in < ADJ_LO);
          s1_next.res_al = cmd_word.al_in - ADJ_LO;
        end
        if (hi) begin
          s1_next.res_al = s1_next.res_al - ADJ_HI;
          s1_next.res_cf = 1'b1;
        end
        s1_next.res_af = lo;
      end
      CMD_AAA: begin
        if (lo) begin
          ax = {cmd_word.ah_in, cmd_word.al_in} + ADJ_AX;
          s1_next.res_al = {4'd0, ax[3:0]};
          s1_next.res_ah = ax[15:8];
        end else begin
          s1_next.res_al = {4'd0, cmd_word.al_in[3:0]};
        end
        s1_next.res_cf = lo;
        s1_next.res_af = lo;
      end
      CMD_AAS: begin
        if (lo) begin
          ax = {cmd_word.ah_in, cmd_word.al_in} - ADJ_AX_LO;
          s1_next.res_al = {4'd0, ax[3:0]};
          s1_next.res_ah = ax[15:8] - 8'd1;
        end else begin
          s1_next.res_al = {4'd0, cmd_word.al_in[3:0]};
        end
        s1_next.res_cf = lo;
        s1_next.res_af = lo;
      end
      default: begin
      end
    endcase
    da = div_step(8'd0, cmd_word.al_in[7], cmd_word.base);
    db = div_step(da[7:0], cmd_word.al_in[6], cmd_word.base);
    s1_next.rem = db[7:0];
    s1_next.quo = {6'd0, da[8], db[8]};
  end

  // stage 2: AAD product, quotient bits 5..4
  always_comb begin
    logic [8:0]  da, db;
    logic [15:0] p;
    p  = s1.ah_orig * s1.base;
    da = div_step(s1.rem, s1.dvd[5], s1.base);
    db = div_step(da[7:0], s1.dvd[4], s1.base);
    s2_next      = s1;
    s2_next.prod = p[7:0];
    s2_next.rem  = db[7:0];
    s2_next.quo  = {s1.quo[5:0], da[8], db[8]};
  end

  // stage 3: AAD sum, quotient bits 3..2
  always_comb begin
    logic [8:0] da, db;
    da = div_step(s2.rem, s2.dvd[3], s2.base);
    db = div_step(da[7:0], s2.dvd[2], s2.base);
    s3_next      = s2;
    s3_next.prod = s2.dvd + s2.prod;
    s3_next.rem  = db[7:0];
    s3_next.quo  = {s2.quo[5:0], da[8], db[8]};
  end

  // stage 4: quotient bits 1..0, result select and flags
  always_comb begin
    logic [8:0] da, db;
    logic [7:0] al;
    logic       szp;
    da  = div_step(s3.rem, s3.dvd[1], s3.base);
    db  = div_step(da[7:0], s3.dvd[0], s3.base);
    szp = 1'b0;
    res_word_next               = '0;
    res_word_next.al_out        = s3.res_al;
    res_word_next.ah_out        = s3.res_ah;
    res_word_next.carry_out     = s3.res_cf;
    res_word_next.aux_carry_out = s3.res_af;
    unique case (s3.cmd)
      CMD_DAA, CMD_DAS: begin
        szp = 1'b1;
      end
      CMD_AAM: begin
        if (s3.base == 8'd0) begin
          res_word_next.divide_error = 1'b1;
        end else begin
          res_word_next.al_out    = db[7:0];
          res_word_next.ah_out    = {s3.quo[5:0], da[8], db[8]};
          res_word_next.carry_out = 1'b0;
          szp = 1'b1;
        end
      end
      CMD_AAD: begin
        res_word_next.al_out    = s3.prod;
        res_word_next.ah_out    = 8'd0;
        res_word_next.carry_out = 1'b0;
        szp = 1'b1;
      end
      default: begin
      end
    endcase
    al = res_word_next.al_out;
    res_word_next.szp_written = szp;
    res_word_next.sign_flag   = szp && al[7];
    res_word_next.zero_flag   = szp && (al == 8'd0);
    res_word_next.parity_flag = szp && !(^al);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      v1        <= cmd_valid;
      v2        <= v1;
      v3        <= v2;
      res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1       <= s1_next;
      s2       <= s2_next;
      s3       <= s3_next;
      res_word <= res_word_next;
    end
  end

endmodule

FILE: hw/rtl/bau_checker.sv
// port-level assertions for the decimal adjust unit, bound to the top level
`include "bcd_adjust_unit_top_macros.svh"

module bau_checker (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_stall,
  input bau_pkg::bau_in_t  cmd_word,
  input logic              res_valid,
  input logic              res_stall,
  input bau_pkg::bau_out_t res_word
);
  import bau_pkg::*;

  logic cmd_take;
  assign cmd_take = cmd_valid && !cmd_stall && (cmd_word.cmd <= CMD_AAD || 1'b1);

  // stalled result word holds
  `BAU_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
    res_valid && $stable(res_word), "res word changed under stall")

  // divide error never comes with updated flags
  `BAU_ASSERT_NOW(a_derr_szp, res_valid && res_word.divide_error,
    !res_word.szp_written, "divide error with szp written")

  // flags read zero when not written
  `BAU_ASSERT_NOW(a_szp_clear, res_valid && !res_word.szp_written,
    !res_word.sign_flag && !res_word.zero_flag && !res_word.parity_flag,
    "unwritten flags not zero")

  // a taken word reaches res_valid when the receiver keeps res_stall low meanwhile
  `BAU_ASSERT_NEXT(a_latency, cmd_take ##1 !res_stall ##1 !res_stall ##1 !res_stall,
    res_valid, "result missing after four cycles")

endmodule

bind bcd_adjust_unit_top bau_checker u_bau_checker (.*);
